/* rtl/ppat_pkg.sv */
// shared types, codes and defaults for the page protect alias translator
package ppat_pkg;

	// default geometry
	localparam int ADDR_BITS_DEF     = 24;
	localparam int PAGE_BITS_DEF     = 12;
	localparam int ALIAS_ENTRIES_DEF = 8;

	// operation codes of a request transaction
	typedef enum logic [2:0] {
		ACT_COMMIT  = 3'd0,
		ACT_PROTECT = 3'd1,
		ACT_MAP     = 3'd2,
		ACT_UNMAP   = 3'd3,
		ACT_RCHECK  = 3'd4,
		ACT_WCHECK  = 3'd5
	} act_t;

	// page access modes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_RW   = 2'd2;

	// one entry of the page table
	typedef struct packed {
		logic       committed;
		logic [1:0] mode;
	} page_ent_t;

	// alias table write commands
	typedef struct packed {
		logic load;
		logic drop;
	} alias_cmd_t;

	// alias table compare results for the entry under scan
	typedef struct packed {
		logic valid;
		logic hit;
		logic overlap;
		logic start_eq;
	} alias_res_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_RANGE,
		ST_PG_RD,
		ST_PG_CHK,
		ST_PG_WR,
		ST_DONE
	} state_t;

endpackage

/* rtl/ppat_if.sv */
// request and response channel interfaces

interface ppat_req_if #(
	parameter int ADDR_BITS = 24
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           action;
	logic [ADDR_BITS-1:0] address;
	logic [ADDR_BITS:0]   size;
	logic [1:0]           access_mode;
	logic [ADDR_BITS-1:0] src_address;

	modport source (output valid, action, address, size, access_mode, src_address,
		input ready);
	modport sink (input valid, action, address, size, access_mode, src_address,
		output ready);
endinterface

interface ppat_rsp_if #(
	parameter int ADDR_BITS = 24,
	parameter int PAGE_BITS = 12
);
	logic                           valid;
	logic                           ready;
	logic                           ok;
	logic [ADDR_BITS-1:0]           backing_address;
	logic [ADDR_BITS-PAGE_BITS:0]   committed_pages;

	modport source (output valid, ok, backing_address, committed_pages, input ready);
	modport sink (input valid, ok, backing_address, committed_pages, output ready);
endinterface

/* rtl/ppat_page_mem.sv */
// page table memory: committed bit and access mode per page, registered read
module ppat_page_mem
	import ppat_pkg::*;
#(
	parameter int PW = 12
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [PW-1:0] rd_addr,
	output page_ent_t     rd_data_q,
	input  logic          wr_en,
	input  logic [PW-1:0] wr_addr,
	input  page_ent_t     wr_data
);

	localparam int DEPTH = 2 ** PW;

	page_ent_t mem_q [DEPTH];

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/ppat_alias_tbl.sv */
// alias window table with the shared window compare unit
module ppat_alias_tbl
	import ppat_pkg::*;
#(
	parameter int ADDR_BITS     = 24,
	parameter int ALIAS_ENTRIES = 8,
	parameter int IW            = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IW-1:0]        idx,
	input  logic [IW-1:0]        wr_idx,
	input  alias_cmd_t           cmd,
	input  logic [ADDR_BITS-1:0] q_addr,
	input  logic [ADDR_BITS+1:0] q_end,
	input  logic [ADDR_BITS-1:0] q_src,
	input  logic [ADDR_BITS:0]   q_len,
	output alias_res_t           res,
	output logic [ADDR_BITS-1:0] backing
);

	logic [ALIAS_ENTRIES-1:0] valid_q;
	logic [ADDR_BITS-1:0]     dst_q [ALIAS_ENTRIES];
	logic [ADDR_BITS-1:0]     src_q [ALIAS_ENTRIES];
	logic [ADDR_BITS:0]       len_q [ALIAS_ENTRIES];

	logic [ADDR_BITS-1:0] e_dst;
	logic [ADDR_BITS+1:0] e_end;
	logic [ADDR_BITS+1:0] q_start;

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.load) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (cmd.drop) begin
				valid_q[idx] <= 1'b0;
			end
		end
	end

	// window fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dst_q[wr_idx] <= q_addr;
			src_q[wr_idx] <= q_src;
			len_q[wr_idx] <= q_len;
		end
	end

	// compare the scanned window against the query range
	always_comb begin
		e_dst        = dst_q[idx];
		e_end        = {2'b00, e_dst} + {1'b0, len_q[idx]};
		q_start      = {2'b00, q_addr};
		res.valid    = valid_q[idx];
		res.hit      = (q_addr >= e_dst) && (q_start < e_end) && (q_end <= e_end);
		res.overlap  = (q_start < e_end) && ({2'b00, e_dst} < q_end);
		res.start_eq = (e_dst == q_addr);
		backing      = src_q[idx] + (q_addr - e_dst);
	end

endmodule

/* rtl/page_protect_alias_translator.sv */
// page protect alias translator top level: sequencer and range arithmetic
//
// After reset the block sweeps the page table once, one page per cycle,
// over all 2**(ADDR_BITS-PAGE_BITS) pages (4096 by default), before the
// first request is taken. Each request then runs alone: accept, decode, for
// map, unmap and checks a scan of the alias table at one entry per cycle
// (map walks every entry, unmap stops at the first matching start, checks
// stop at the first hit), a range step for checks, and per page touched a
// read of the page table, then a test or write; protect walks its pages
// twice, testing them and then writing them. A done state hands the result
// to the response register, which can hold a finished result while the next
// request is accepted.
module page_protect_alias_translator
	import ppat_pkg::*;
#(
	parameter int ADDR_BITS     = ADDR_BITS_DEF,
	parameter int PAGE_BITS     = PAGE_BITS_DEF,
	parameter int ALIAS_ENTRIES = ALIAS_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ppat_req_if.sink  req,
	ppat_rsp_if.source rsp
);

	localparam int PW = ADDR_BITS - PAGE_BITS;
	localparam int CW = PW + 1;
	localparam int IW = (ALIAS_ENTRIES > 1) ? $clog2(ALIAS_ENTRIES) : 1;
	localparam int SW = $clog2(ALIAS_ENTRIES + 1);
	localparam logic [ADDR_BITS+1:0] SPACE = {2'b01, {ADDR_BITS{1'b0}}};

	state_t state_q, state_d;

	logic [2:0]           act_q;
	logic [ADDR_BITS-1:0] a_q;
	logic [ADDR_BITS:0]   n_q;
	logic [1:0]           mode_q;
	logic [ADDR_BITS-1:0] src_q;
	logic [ADDR_BITS-1:0] b_q;
	logic [PW-1:0]        p_q;
	logic [PW-1:0]        hi_q;
	logic [PW-1:0]        clr_q;
	logic [SW-1:0]        scan_q;
	logic [IW-1:0]        slot_q;
	logic                 ovl_q;
	logic                 found_q;
	logic                 bad_q;
	logic                 res_ok_q;
	logic [ADDR_BITS-1:0] res_back_q;
	logic [CW-1:0]        count_q;

	logic                 rsp_valid_q;
	logic                 rsp_ok_q;
	logic [ADDR_BITS-1:0] rsp_back_q;
	logic [CW-1:0]        rsp_cnt_q;

	logic [ADDR_BITS-1:0] x_sel;
	logic [ADDR_BITS+1:0] sum_x;
	logic [ADDR_BITS+1:0] end_x;
	logic [ADDR_BITS+1:0] sum_s;
	logic                 fits_x;
	logic                 fits_s;
	logic                 self_ovl;
	logic                 n_zero;
	logic                 scan_done;
	logic [PW-1:0]        first_x;
	logic [PW-1:0]        last_x;
	logic [IW-1:0]        idx;

	logic        rd_en;
	logic        wr_en;
	logic [PW-1:0] wr_addr;
	page_ent_t   wr_data;
	page_ent_t   pd;
	alias_cmd_t  acmd;
	alias_res_t  ares;
	logic [ADDR_BITS-1:0] a_back;
	logic        fin;
	logic        fin_ok;
	logic        accept;
	logic        rsp_load;

	// range arithmetic on the request address, or the resolved one for checks
	always_comb begin
		x_sel     = (state_q == ST_RANGE) ? b_q : a_q;
		sum_x     = {2'b00, x_sel} + {1'b0, n_q};
		end_x     = sum_x - {{(ADDR_BITS+1){1'b0}}, 1'b1};
		sum_s     = {2'b00, src_q} + {1'b0, n_q};
		fits_x    = (sum_x <= SPACE);
		fits_s    = (sum_s <= SPACE);
		self_ovl  = ({2'b00, a_q} < sum_s) && ({2'b00, src_q} < sum_x);
		n_zero    = (n_q == '0);
		scan_done = (scan_q == SW'(ALIAS_ENTRIES));
		first_x   = x_sel[ADDR_BITS-1:PAGE_BITS];
		last_x    = end_x[ADDR_BITS-1:PAGE_BITS];
		idx       = scan_q[IW-1:0];
	end

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	ppat_page_mem #(
		.PW (PW)
	) u_page_mem (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (p_q),
		.rd_data_q (pd),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	ppat_alias_tbl #(
		.ADDR_BITS     (ADDR_BITS),
		.ALIAS_ENTRIES (ALIAS_ENTRIES),
		.IW            (IW)
	) u_alias_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.idx     (idx),
		.wr_idx  (slot_q),
		.cmd     (acmd),
		.q_addr  (a_q),
		.q_end   (sum_x),
		.q_src   (src_q),
		.q_len   (n_q),
		.res     (ares),
		.backing (a_back)
	);

	// next state and memory / table controls
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = p_q;
		wr_data = '{committed: 1'b1, mode: MODE_RW};
		acmd    = '0;
		fin     = 1'b0;
		fin_ok  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '{committed: 1'b0, mode: MODE_RW};
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (act_q) inside
					ACT_COMMIT: begin
						if (n_zero || !fits_x) fin = 1'b1;
						else state_d = ST_PG_RD;
					end
					ACT_PROTECT: begin
						if (n_zero || !fits_x || (mode_q > MODE_RW)) fin = 1'b1;
						else state_d = ST_PG_RD;
					end
					ACT_MAP: begin
						if (n_zero || !fits_x || !fits_s || self_ovl) fin = 1'b1;
						else state_d = ST_SCAN;
					end
					ACT_UNMAP, ACT_RCHECK, ACT_WCHECK: begin
						state_d = ST_SCAN;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_SCAN: begin
				unique case (act_q) inside
					ACT_MAP: begin
						if (scan_done) begin
							fin = 1'b1;
							if (!ovl_q && found_q) begin
								fin_ok    = 1'b1;
								acmd.load = 1'b1;
							end
						end
					end
					ACT_UNMAP: begin
						if (scan_done) begin
							fin = 1'b1;
						end else if (ares.valid && ares.start_eq) begin
							acmd.drop = 1'b1;
							fin       = 1'b1;
							fin_ok    = 1'b1;
						end
					end
					default: begin
						if (scan_done || (ares.valid && ares.hit)) begin
							state_d = ST_RANGE;
						end
					end
				endcase
			end
			ST_RANGE: begin
				if (bad_q || !fits_x) fin = 1'b1;
				else state_d = ST_PG_RD;
			end
			ST_PG_RD: begin
				rd_en   = 1'b1;
				state_d = ST_PG_CHK;
			end
			ST_PG_CHK: begin
				unique case (act_q) inside
					ACT_COMMIT: begin
						wr_en = 1'b1;
						if (p_q == hi_q) begin
							fin    = 1'b1;
							fin_ok = 1'b1;
						end else begin
							state_d = ST_PG_RD;
						end
					end
					ACT_PROTECT: begin
						if (!pd.committed) fin = 1'b1;
						else if (p_q == hi_q) state_d = ST_PG_WR;
						else state_d = ST_PG_RD;
					end
					default: begin
						if (!pd.committed ||
								((act_q == ACT_WCHECK) ? (pd.mode != MODE_RW)
								                       : (pd.mode == MODE_NONE))) begin
							fin = 1'b1;
						end else if (p_q == hi_q) begin
							fin    = 1'b1;
							fin_ok = 1'b1;
						end else begin
							state_d = ST_PG_RD;
						end
					end
				endcase
			end
			ST_PG_WR: begin
				wr_en   = 1'b1;
				wr_data = '{committed: 1'b1, mode: mode_q};
				if (p_q == hi_q) begin
					fin    = 1'b1;
					fin_ok = 1'b1;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = ST_DONE;
		end
	end

	assign rsp_load = (state_q == ST_DONE) && (state_d == ST_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if ((state_q == ST_PG_CHK) && (act_q == ACT_COMMIT) && !pd.committed) begin
				count_q <= count_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the transaction in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= req.action;
			a_q        <= req.address;
			n_q        <= req.size;
			mode_q     <= req.access_mode;
			src_q      <= req.src_address;
			res_back_q <= '0;
			scan_q     <= '0;
			ovl_q      <= 1'b0;
			found_q    <= 1'b0;
		end
		unique case (state_q)
			ST_DECODE: begin
				p_q   <= first_x;
				hi_q  <= last_x;
				bad_q <= n_zero || !fits_x;
				b_q   <= a_q;
			end
			ST_SCAN: begin
				scan_q <= scan_q + 1'b1;
				if (!scan_done) begin
					if (ares.valid && ares.overlap) begin
						ovl_q <= 1'b1;
					end
					if (!ares.valid && !found_q) begin
						slot_q  <= idx;
						found_q <= 1'b1;
					end
					if (ares.valid && ares.hit) begin
						b_q <= a_back;
					end
				end
			end
			ST_RANGE: begin
				p_q        <= first_x;
				hi_q       <= last_x;
				res_back_q <= b_q;
			end
			ST_PG_CHK: begin
				if ((act_q == ACT_PROTECT) && (p_q == hi_q)) p_q <= first_x;
				else p_q <= p_q + 1'b1;
			end
			ST_PG_WR: begin
				p_q <= p_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (fin) begin
			res_ok_q <= fin_ok;
		end
		if (rsp_load) begin
			rsp_ok_q   <= res_ok_q;
			rsp_back_q <= res_back_q;
			rsp_cnt_q  <= count_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.ok              = rsp_ok_q;
	assign rsp.backing_address = rsp_back_q;
	assign rsp.committed_pages = rsp_cnt_q;

endmodule

/* rtl/ppat_checker.sv */
// port checker for the page protect alias translator, with its bind
module ppat_checker
	import ppat_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_ok,
	input logic [ADDR_BITS-1:0]         rsp_back,
	input logic [ADDR_BITS-PAGE_BITS:0] rsp_cnt
);

	localparam int PW = ADDR_BITS - PAGE_BITS;
	localparam logic [PW:0] NUM_PAGES = {1'b1, {PW{1'b0}}};

	logic [PW:0] last_cnt_q;

	// committed count of the last response transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			last_cnt_q <= rsp_cnt;
		end
	end

	// a stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// a stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_ok) && $stable(rsp_back) && $stable(rsp_cnt))
		else $error("response payload changed while stalled");

	// committed page count never falls
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_cnt >= last_cnt_q)
		else $error("committed page count decreased");

	// committed page count bounded by the page table size
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_cnt <= NUM_PAGES)
		else $error("committed page count beyond page table");

endmodule

bind page_protect_alias_translator ppat_checker #(
	.ADDR_BITS (ADDR_BITS),
	.PAGE_BITS (PAGE_BITS)
) u_ppat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_ok    (rsp.ok),
	.rsp_back  (rsp.backing_address),
	.rsp_cnt   (rsp.committed_pages)
);
